[rtl/stq_pkg.sv]
// Package for the sorted timeout queue: sizes, input kind and status codes,
// and the types shared by the cell chain and its controller.
// Depends on nothing.
package stq_pkg;

	localparam int DEPTH     = 16;
	localparam int TIME_BITS = 32;
	localparam int ID_BITS   = 10;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam int S_DATA_BITS = ((ID_BITS + 2 * TIME_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = ((ID_BITS + 2 + 7) / 8) * 8;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ADJUST = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_DUPLICATE = 2'd3
	} status_t;

	typedef struct packed {
		logic                 valid;
		logic [TIME_BITS-1:0] expiry;
		logic [ID_BITS-1:0]   owner;
	} entry_t;

	// Per-cell command from the controller.
	typedef struct packed {
		logic                 ins;
		logic                 shl;
		logic [TIME_BITS-1:0] cmp_time;
		logic [TIME_BITS-1:0] new_expiry;
		logic [ID_BITS-1:0]   key_id;
	} cell_cmd_t;

	// What a cell reports to the controller and its neighbors.
	typedef struct packed {
		logic le;
		logic match;
	} cell_flags_t;

endpackage

[rtl/stq_cell.sv]
// One slot of the sorted timeout queue. It holds an entry, compares it with
// the command's time and id, and takes new data, its left or its right
// neighbor's entry. Depends on stq_pkg.
module stq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::cell_cmd_t  cmd,
	input  logic                shl_en,
	input  logic                left_le,
	input  stq_pkg::entry_t     left_entry,
	input  stq_pkg::entry_t     right_entry,
	output stq_pkg::entry_t     entry,
	output stq_pkg::cell_flags_t flags
);

	logic                          valid_q;
	logic [stq_pkg::TIME_BITS-1:0] expiry_q;
	logic [stq_pkg::ID_BITS-1:0]   owner_q;

	assign entry.valid  = valid_q;
	assign entry.expiry = expiry_q;
	assign entry.owner  = owner_q;

	assign flags.le    = valid_q && (expiry_q <= cmd.cmp_time);
	assign flags.match = valid_q && (owner_q == cmd.key_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !flags.le) begin
			valid_q <= left_le ? 1'b1 : left_entry.valid;
		end else if (cmd.shl && shl_en) begin
			valid_q <= right_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !flags.le) begin
			if (left_le) begin
				expiry_q <= cmd.new_expiry;
				owner_q  <= cmd.key_id;
			end else begin
				expiry_q <= left_entry.expiry;
				owner_q  <= left_entry.owner;
			end
		end else if (cmd.shl && shl_en) begin
			expiry_q <= right_entry.expiry;
			owner_q  <= right_entry.owner;
		end
	end

endmodule

[rtl/sorted_timeout_queue.sv]
// Sorted timeout queue: a controller and a chain of stq_cell slots.
// Depends on stq_pkg and stq_cell.
//
// Usage: each slave transfer carries a command kind in s_tuser and entry id,
// expiry time and current time in s_tdata. Insert, adjust and delete each
// produce one master transfer with a status code. A tick produces one
// transfer per expired entry, oldest first, with m_tuser set and m_tlast on
// the final one; a tick that finds nothing expired produces one transfer
// with m_tuser low and m_tlast high.
// Timing: insert and delete pass from acceptance through the execute state to
// the output register; adjust goes through the execute state (a removal shift)
// and then the insert state (an insertion shift). A tick passes through the
// execute state into the tick state, where the cells compare against the current
// time and the chain shifts one slot each time the head entry is emitted.
// A new command is accepted only once the previous one has finished; its
// result sits in the output register while the next command is taken.
// When the receiver stalls, the chain waits until the output register is
// free. Reset empties the queue and clears the output register.
module sorted_timeout_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_id, expire_time, now_time, zero fill
	input  logic [stq_pkg::S_DATA_BITS-1:0] s_tdata,
	// kind
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// expired_id, status, zero fill
	output logic [stq_pkg::M_DATA_BITS-1:0] m_tdata,
	// expired_valid
	output logic                            m_tuser,
	output logic                            m_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_INS  = 4'b0100,
		ST_TICK = 4'b1000
	} state_t;

	localparam int TB = stq_pkg::TIME_BITS;
	localparam int IB = stq_pkg::ID_BITS;

	state_t state_q, state_d;

	stq_pkg::kind_t            kind_q;
	logic [IB-1:0]             id_q;
	logic [TB-1:0]             exp_q;
	logic [TB-1:0]             now_q;
	logic [stq_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

	stq_pkg::entry_t      cell_entry [stq_pkg::DEPTH];
	stq_pkg::cell_flags_t cell_flags [stq_pkg::DEPTH];
	logic [stq_pkg::DEPTH-1:0] match_vec;
	logic [stq_pkg::DEPTH-1:0] shl_en;
	stq_pkg::cell_cmd_t   cmd;
	logic                 cmd_ins;
	logic                 cmd_shl;

	logic                         found;
	logic                         full;
	logic [stq_pkg::IDX_BITS-1:0] found_pos;
	logic [stq_pkg::IDX_BITS-1:0] shl_pos;
	logic                         out_free;

	logic                   emit;
	logic [IB-1:0]          e_id;
	logic                   e_valid;
	stq_pkg::status_t       e_status;
	logic                   e_last;

	logic                   m_valid_q;
	logic [IB-1:0]          m_id_q;
	logic                   m_xv_q;
	stq_pkg::status_t       m_status_q;
	logic                   m_last_q;

	localparam stq_pkg::entry_t EMPTY_ENTRY = '{valid: 1'b0, expiry: '0, owner: '0};

	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_tready;
	assign full     = (cnt_q == stq_pkg::CNT_BITS'(stq_pkg::DEPTH));
	assign found    = |match_vec;

	always_comb begin
		found_pos = '0;
		for (int i = 0; i < stq_pkg::DEPTH; i++) begin
			match_vec[i] = cell_flags[i].match;
			if (cell_flags[i].match) begin
				found_pos = found_pos | stq_pkg::IDX_BITS'(i);
			end
		end
	end

	assign cmd = '{
		ins:        cmd_ins,
		shl:        cmd_shl,
		cmp_time:   (state_q == ST_TICK) ? now_q : exp_q,
		new_expiry: exp_q,
		key_id:     id_q
	};

	genvar g;
	generate
		for (g = 0; g < stq_pkg::DEPTH; g++) begin : g_cell
			stq_pkg::entry_t left_e;
			stq_pkg::entry_t right_e;
			logic            left_le;

			assign shl_en[g] = (stq_pkg::IDX_BITS'(g) >= shl_pos);

			if (g == 0) begin : g_first
				assign left_e  = EMPTY_ENTRY;
				assign left_le = 1'b1;
			end else begin : g_mid
				assign left_e  = cell_entry[g-1];
				assign left_le = cell_flags[g-1].le;
			end

			if (g == stq_pkg::DEPTH - 1) begin : g_last
				assign right_e = EMPTY_ENTRY;
			end else begin : g_inner
				assign right_e = cell_entry[g+1];
			end

			stq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.shl_en      (shl_en[g]),
				.left_le     (left_le),
				.left_entry  (left_e),
				.right_entry (right_e),
				.entry       (cell_entry[g]),
				.flags       (cell_flags[g])
			);
		end
	endgenerate

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd_ins  = 1'b0;
		cmd_shl  = 1'b0;
		shl_pos  = found_pos;
		emit     = 1'b0;
		e_id     = '0;
		e_valid  = 1'b0;
		e_status = stq_pkg::STAT_OK;
		e_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (kind_q)
					stq_pkg::KIND_INSERT: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (found) begin
								e_status = stq_pkg::STAT_DUPLICATE;
							end else if (full) begin
								e_status = stq_pkg::STAT_FULL;
							end else begin
								cmd_ins = 1'b1;
								cnt_d   = cnt_q + 1'b1;
							end
						end
					end
					stq_pkg::KIND_ADJUST: begin
						if (!found) begin
							if (out_free) begin
								emit     = 1'b1;
								e_status = stq_pkg::STAT_NOT_FOUND;
								state_d  = ST_IDLE;
							end
						end else begin
							cmd_shl = 1'b1;
							cnt_d   = cnt_q - 1'b1;
							state_d = ST_INS;
						end
					end
					stq_pkg::KIND_DELETE: begin
						if (out_free) begin
							emit    = 1'b1;
							state_d = ST_IDLE;
							if (!found) begin
								e_status = stq_pkg::STAT_NOT_FOUND;
							end else begin
								cmd_shl = 1'b1;
								cnt_d   = cnt_q - 1'b1;
							end
						end
					end
					stq_pkg::KIND_TICK: begin
						state_d = ST_TICK;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_INS: begin
				if (out_free) begin
					cmd_ins = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (out_free) begin
					emit = 1'b1;
					if (cell_flags[0].le) begin
						e_id    = cell_entry[0].owner;
						e_valid = 1'b1;
						e_last  = !cell_flags[1].le;
						cmd_shl = 1'b1;
						shl_pos = '0;
						cnt_d   = cnt_q - 1'b1;
						if (!cell_flags[1].le) begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= stq_pkg::kind_t'(s_tuser);
			id_q   <= s_tdata[IB-1:0];
			exp_q  <= s_tdata[IB+TB-1:IB];
			now_q  <= s_tdata[IB+2*TB-1:IB+TB];
		end
		if (emit) begin
			m_id_q     <= e_id;
			m_xv_q     <= e_valid;
			m_status_q <= e_status;
			m_last_q   <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(stq_pkg::M_DATA_BITS - IB - 2){1'b0}}, m_status_q, m_id_q};
	assign m_tuser  = m_xv_q;
	assign m_tlast  = m_last_q;

endmodule

[tb/sv/tb.sv]
// Testbench for sorted_timeout_queue: directed and random timer commands over
// the stream ports, every result transfer checked by a scoreboard class.
// Depends on stq_pkg and the sorted_timeout_queue RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [stq_pkg::ID_BITS-1:0] id;
		logic                        valid;
		stq_pkg::status_t            status;
		logic                        last;
	} timeout_result_t;

	class timeout_scoreboard;
		logic [stq_pkg::TIME_BITS-1:0] held_expiry[stq_pkg::DEPTH];
		logic [stq_pkg::ID_BITS-1:0]   held_id[stq_pkg::DEPTH];
		int                            held_count;
		timeout_result_t               awaited[$];
		int                            mismatches;
		int                            checked;
		int                            commands;
		int                            expirations;
		int                            n_full;
		int                            n_missing;
		int                            n_dup;

		function new();
			held_count  = 0;
			mismatches  = 0;
			checked     = 0;
			commands    = 0;
			expirations = 0;
			n_full      = 0;
			n_missing   = 0;
			n_dup       = 0;
		endfunction

		function int find_slot(logic [stq_pkg::ID_BITS-1:0] id);
			for (int i = 0; i < held_count; i++)
				if (held_id[i] == id)
					return i;
			return -1;
		endfunction

		function void remove_slot(int pos);
			for (int i = pos; i + 1 < held_count; i++) begin
				held_expiry[i] = held_expiry[i+1];
				held_id[i]     = held_id[i+1];
			end
			held_count--;
		endfunction

		function void insert_sorted(logic [stq_pkg::ID_BITS-1:0] id,
			logic [stq_pkg::TIME_BITS-1:0] exp);
			int pos;
			pos = 0;
			while (pos < held_count && held_expiry[pos] <= exp)
				pos++;
			for (int i = held_count; i > pos; i--) begin
				held_expiry[i] = held_expiry[i-1];
				held_id[i]     = held_id[i-1];
			end
			held_expiry[pos] = exp;
			held_id[pos]     = id;
			held_count++;
		endfunction

		function void push_result(logic [stq_pkg::ID_BITS-1:0] id, logic valid,
			stq_pkg::status_t status, logic last);
			timeout_result_t r;
			r.id     = id;
			r.valid  = valid;
			r.status = status;
			r.last   = last;
			awaited.push_back(r);
		endfunction

		function void note_command(stq_pkg::kind_t kind, logic [stq_pkg::ID_BITS-1:0] id,
			logic [stq_pkg::TIME_BITS-1:0] exp, logic [stq_pkg::TIME_BITS-1:0] now);
			stq_pkg::status_t status;
			int               pos;
			int               n;
			status = stq_pkg::STAT_OK;
			commands++;
			case (kind)
				stq_pkg::KIND_INSERT: begin
					if (find_slot(id) >= 0)
						status = stq_pkg::STAT_DUPLICATE;
					else if (held_count >= stq_pkg::DEPTH)
						status = stq_pkg::STAT_FULL;
					else
						insert_sorted(id, exp);
				end
				stq_pkg::KIND_ADJUST: begin
					pos = find_slot(id);
					if (pos < 0) begin
						status = stq_pkg::STAT_NOT_FOUND;
					end else begin
						remove_slot(pos);
						insert_sorted(id, exp);
					end
				end
				stq_pkg::KIND_DELETE: begin
					pos = find_slot(id);
					if (pos < 0)
						status = stq_pkg::STAT_NOT_FOUND;
					else
						remove_slot(pos);
				end
				default: begin
					n = 0;
					while (held_count > 0 && held_expiry[0] <= now) begin
						push_result(held_id[0], 1'b1, stq_pkg::STAT_OK, held_count == 1 ||
							held_expiry[1] > now);
						remove_slot(0);
						n++;
					end
					expirations += n;
					if (n == 0)
						push_result('0, 1'b0, stq_pkg::STAT_OK, 1'b1);
					return;
				end
			endcase
			case (status)
				stq_pkg::STAT_FULL:      n_full++;
				stq_pkg::STAT_NOT_FOUND: n_missing++;
				stq_pkg::STAT_DUPLICATE: n_dup++;
				default: ;
			endcase
			push_result('0, 1'b0, status, 1'b1);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("tb: mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void check_transfer(logic [stq_pkg::ID_BITS-1:0] id, logic [1:0] status,
			logic valid, logic last);
			timeout_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected transfer id=%0d status=%0d valid=%b last=%b",
					id, status, valid, last));
				return;
			end
			want = awaited.pop_front();
			if (want.id !== id || want.valid !== valid || want.status !== status ||
				want.last !== last)
				report($sformatf({"expected id=%0d status=%0d valid=%b last=%b, ",
					"got id=%0d status=%0d valid=%b last=%b"},
					want.id, want.status, want.valid, want.last, id, status, valid, last));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [stq_pkg::S_DATA_BITS-1:0] s_tdata = '0;
	logic [1:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [stq_pkg::M_DATA_BITS-1:0] m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;

	timeout_scoreboard sb;
	int                send_burst = 0;
	int                drain_burst = 0;

	sorted_timeout_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst = $urandom_range(8, 20);
		return $urandom_range(0, 13);
	endfunction

	task automatic send_command(input stq_pkg::kind_t kind,
		input logic [stq_pkg::ID_BITS-1:0] id, input logic [stq_pkg::TIME_BITS-1:0] exp,
		input logic [stq_pkg::TIME_BITS-1:0] now);
		int                              gap;
		logic [stq_pkg::S_DATA_BITS-1:0] word;
		gap = draw_gap(send_burst);
		word = '0;
		word[stq_pkg::ID_BITS-1:0] = id;
		word[stq_pkg::ID_BITS +: stq_pkg::TIME_BITS] = exp;
		word[stq_pkg::ID_BITS+stq_pkg::TIME_BITS +: stq_pkg::TIME_BITS] = now;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sb.note_command(kind, id, exp, now);
	endtask

	initial begin : drain
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_gap(drain_burst);
			if (sb.checked == 30)
				stall = 240;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_transfer(m_tdata[stq_pkg::ID_BITS-1:0], m_tdata[stq_pkg::ID_BITS +: 2],
				m_tuser, m_tlast);
		end
	end

	initial begin : stimulus
		logic [stq_pkg::ID_BITS-1:0]   id_pool[24];
		logic [stq_pkg::ID_BITS-1:0]   id;
		logic [stq_pkg::TIME_BITS-1:0] base;
		logic [stq_pkg::TIME_BITS-1:0] clock_now;
		int                            pick;
		int                            waited;
		sb = new();
		for (int i = 0; i < 24; i++)
			id_pool[i] = stq_pkg::ID_BITS'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(stq_pkg::KIND_INSERT, 10'd0, 32'd0, $urandom);
		send_command(stq_pkg::KIND_INSERT, 10'd1023, 32'hFFFF_FFFF, $urandom);
		send_command(stq_pkg::KIND_INSERT, 10'd0, $urandom, $urandom);
		send_command(stq_pkg::KIND_ADJUST, 10'd555, $urandom, $urandom);
		send_command(stq_pkg::KIND_DELETE, 10'd555, $urandom, $urandom);
		send_command(stq_pkg::KIND_ADJUST, 10'd1023, 32'd5, $urandom);
		send_command(stq_pkg::KIND_TICK, stq_pkg::ID_BITS'($urandom), $urandom, 32'd0);
		send_command(stq_pkg::KIND_TICK, stq_pkg::ID_BITS'($urandom), $urandom, 32'd3);
		send_command(stq_pkg::KIND_INSERT, 10'd7, 32'd5, $urandom);
		for (int i = 0; i < 14; i++)
			send_command(stq_pkg::KIND_INSERT, stq_pkg::ID_BITS'(100 + i),
				$urandom_range(6, 1000), $urandom);
		send_command(stq_pkg::KIND_INSERT, 10'd300, $urandom, $urandom);
		send_command(stq_pkg::KIND_DELETE, 10'd100, $urandom, $urandom);
		send_command(stq_pkg::KIND_ADJUST, 10'd7, 32'd2000, $urandom);
		send_command(stq_pkg::KIND_INSERT, 10'd200, 32'd5, $urandom);
		send_command(stq_pkg::KIND_TICK, stq_pkg::ID_BITS'($urandom), $urandom,
			32'hFFFF_FFFF);

		base = '0;
		clock_now = '0;
		for (int n = 0; n < 76; n++) begin
			if (n % 25 == 0) begin
				base = $urandom;
				clock_now = '0;
			end
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				id = stq_pkg::ID_BITS'($urandom);
			else
				id = id_pool[$urandom_range(0, 23)];
			if (pick < 5)
				send_command(stq_pkg::kind_t'($urandom_range(0, 3)),
					stq_pkg::ID_BITS'($urandom), $urandom, $urandom);
			else if (pick < 45)
				send_command(stq_pkg::KIND_INSERT, id,
					base + clock_now + $urandom_range(0, 40), $urandom);
			else if (pick < 65)
				send_command(stq_pkg::KIND_ADJUST, id,
					base + clock_now + $urandom_range(0, 40), $urandom);
			else if (pick < 78)
				send_command(stq_pkg::KIND_DELETE, id, $urandom, $urandom);
			else begin
				clock_now = clock_now + $urandom_range(0, 12);
				send_command(stq_pkg::KIND_TICK, id, $urandom, base + clock_now);
			end
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (sb.awaited.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		$display("tb: %0d commands sent, %0d result transfers checked, %0d expirations",
			sb.commands, sb.checked, sb.expirations);
		$display("tb: rejections: %0d full, %0d not found, %0d duplicate; %0d results missing",
			sb.n_full, sb.n_missing, sb.n_dup, sb.awaited.size());
		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: timeout, %0d results still awaited", sb.awaited.size());
		$display("tb: FAIL");
		$finish;
	end

endmodule
